FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define EPOC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define EPOC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/epoc_pkg.sv
package epoc_pkg;

   localparam int unsigned PAT_BYTES = 32;
   localparam int unsigned NUM_WORDS = 4;
   localparam int unsigned WORD_W    = 64;
   localparam int unsigned LEN_W     = 6;
   localparam int unsigned IDX_W     = 5;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned POS_W     = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_WORD_0 = 3'd1,
      CSR_PATTERN_WORD_1 = 3'd2,
      CSR_PATTERN_WORD_2 = 3'd3,
      CSR_PATTERN_WORD_3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } shift_ctl_type;

   function automatic logic [7:0] pattern_byte(input logic [PAT_BYTES*8-1:0] pat,
                                                input logic [IDX_W-1:0] idx);
      return pat[idx*8 +: 8];
   endfunction

endpackage

FILE: src/epoc_req_if.sv
interface epoc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       text_end;

   modport source (output valid, output text_byte, output text_end, input ready);
   modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

FILE: src/epoc_rsp_if.sv
interface epoc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       match_found;
   logic [epoc_pkg::POS_W-1:0] match_start;
   logic [epoc_pkg::POS_W-1:0] match_total;
   logic                       is_final;

   modport source (output valid, output match_found, output match_start,
                   output match_total, output is_final, input ready);
   modport sink   (input valid, input match_found, input match_start,
                   input match_total, input is_final, output ready);
endinterface

FILE: src/epoc_cell.sv
module epoc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  epoc_pkg::shift_ctl_type ctl,
   input  logic [7:0]              byte_in,
   input  logic                    valid_in,
   input  logic [7:0]              pat_byte,
   input  logic                    active,
   output logic [7:0]              byte_out,
   output logic                    valid_out,
   output logic                    eq_out
);
   import epoc_pkg::*;

   logic [7:0] byte_ff;
   logic       valid_ff;
   logic       eq_ff;
   logic       eq_in;

   // Compare against the byte that lands here on this shift.
   assign eq_in = !active || (valid_in && (byte_in == pat_byte));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= valid_in && !ctl.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= byte_in;
         eq_ff   <= eq_in;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;
   assign eq_out    = eq_ff;
endmodule

FILE: src/epoc_window.sv
module epoc_window #(
   parameter int unsigned PAT_MAX = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  epoc_pkg::shift_ctl_type              ctl,
   input  logic [7:0]                           text_byte,
   input  logic [epoc_pkg::PAT_BYTES*8-1:0]     pattern,
   input  logic [epoc_pkg::LEN_W-1:0]           len_used,
   output logic                                 match
);
   import epoc_pkg::*;

   logic [7:0]         byte_q  [PAT_MAX];
   logic [PAT_MAX-1:0] valid_q;
   logic [PAT_MAX-1:0] eq_q;

   for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
      logic [LEN_W:0] pat_sel;
      logic [7:0]     byte_in;
      logic           valid_in;
      logic           active;

      // Cell k holds the byte k steps old; it faces pattern byte len-1-k.
      assign pat_sel = (LEN_W+1)'(len_used) - (LEN_W+1)'(k) - (LEN_W+1)'(1);
      assign active  = (LEN_W+1)'(len_used) > (LEN_W+1)'(k);

      if (k == 0) begin : g_head
         assign byte_in  = text_byte;
         assign valid_in = 1'b1;
      end else begin : g_link
         assign byte_in  = byte_q[k-1];
         assign valid_in = valid_q[k-1];
      end

      epoc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .byte_in   (byte_in),
         .valid_in  (valid_in),
         .pat_byte  (pattern_byte(pattern, pat_sel[IDX_W-1:0])),
         .active    (active),
         .byte_out  (byte_q[k]),
         .valid_out (valid_q[k]),
         .eq_out    (eq_q[k])
      );
   end

   assign match = &eq_q;
endmodule

FILE: src/exact_pattern_occurrence_counter.sv
// A result passes the window and stage 1 registers, then the output register.
// Throughput: one text byte per cycle; the byte window is a chain of compare
// cells that shift once per accepted request, and a stalled result holds the chain.
// Reset (synchronous, active high): pattern length 1, pattern bytes 0; window valid
// flags, byte position and occurrence count cleared; ready the cycle after reset.
`include "assert_macros.svh"

module exact_pattern_occurrence_counter #(
   parameter int unsigned PAT_MAX = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   epoc_req_if.sink                        req_ch,
   epoc_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [epoc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [epoc_pkg::WORD_W-1:0]     csr_wdata
);
   import epoc_pkg::*;

   localparam int unsigned LEN_CAP = (PAT_MAX < PAT_BYTES) ? PAT_MAX : PAT_BYTES;

   logic [LEN_W-1:0]       len_ff;
   logic [WORD_W-1:0]      pat_ff [NUM_WORDS];
   logic [PAT_BYTES*8-1:0] pattern;
   logic [LEN_W-1:0]       len_used;

   logic                   adv;
   logic                   req_fire;
   shift_ctl_type          ctl;
   logic                   hit;

   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [POS_W-1:0]       s1_start_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [POS_W-1:0]       pos_in;
   logic [POS_W-1:0]       count_ff;
   logic [POS_W-1:0]       count_in;

   logic                   out_valid_ff;
   logic                   out_found_ff;
   logic [POS_W-1:0]       out_start_ff;
   logic [POS_W-1:0]       out_total_ff;
   logic                   out_final_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         for (int w = 0; w < NUM_WORDS; w++) begin
            pat_ff[w] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH: len_ff    <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_WORD_0: pat_ff[0] <= csr_wdata;
            CSR_PATTERN_WORD_1: pat_ff[1] <= csr_wdata;
            CSR_PATTERN_WORD_2: pat_ff[2] <= csr_wdata;
            CSR_PATTERN_WORD_3: pat_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar w = 0; w < NUM_WORDS; w++) begin : g_pat
      assign pattern[w*WORD_W +: WORD_W] = pat_ff[w];
   end

   always_comb begin
      if (len_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (len_ff > LEN_W'(LEN_CAP)) begin
         len_used = LEN_W'(LEN_CAP);
      end else begin
         len_used = len_ff;
      end
   end

   // Handshake: the whole pipe advances when the output register is free.
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign req_fire     = req_ch.valid && adv;
   assign ctl.shift    = req_fire;
   assign ctl.clear    = req_ch.text_end;

   epoc_window #(
      .PAT_MAX (PAT_MAX)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .text_byte (req_ch.text_byte),
      .pattern   (pattern),
      .len_used  (len_used),
      .match     (hit)
   );

   // Stage 1: byte position alongside the window shift
   assign pos_in = req_ch.text_end ? '0 : pos_ff + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
      end else if (adv) begin
         s1_valid_ff <= req_ch.valid;
         if (req_ch.valid) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_last_ff  <= req_ch.text_end;
         s1_start_ff <= pos_ff - POS_W'(len_used - LEN_W'(1));
      end
   end

   // Stage 2: count and build the result; saturate the count
   assign count_in = (hit && (count_ff != '1)) ? count_ff + POS_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (adv) begin
         out_valid_ff <= s1_valid_ff && (hit || s1_last_ff);
         if (s1_valid_ff) begin
            count_ff <= s1_last_ff ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         out_found_ff <= hit;
         out_start_ff <= hit ? s1_start_ff : '0;
         out_total_ff <= count_in;
         out_final_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.match_found = out_found_ff;
   assign rsp_ch.match_start = out_start_ff;
   assign rsp_ch.match_total = out_total_ff;
   assign rsp_ch.is_final    = out_final_ff;

   `EPOC_ASSERT_ALWAYS(a_reset_empties_output, clock, reset |=> !rsp_ch.valid, "output valid after reset")
   `EPOC_ASSERT(a_nohit_is_final, clock, reset, (rsp_ch.valid && !rsp_ch.match_found) |-> rsp_ch.is_final, "empty result that is not final")
   `EPOC_ASSERT(a_hit_counted, clock, reset, (rsp_ch.valid && rsp_ch.match_found) |-> (rsp_ch.match_total != '0), "match with zero total")
   `EPOC_ASSERT(a_end_clears_count, clock, reset, (adv && s1_valid_ff && s1_last_ff) |=> (count_ff == '0), "count kept past end of text")
endmodule
